FILE: design/aes128_ctr_stream_cipher_unit_macros.svh
// assertion macros for the aes-128 ctr unit checker
`ifndef AES128_CTR_STREAM_CIPHER_UNIT_MACROS_SVH
`define AES128_CTR_STREAM_CIPHER_UNIT_MACROS_SVH
// an implication checked every clock outside reset
`define ACU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// an implication whose consequent is checked in the cycle after the antecedent
`define ACU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/acu_pkg.sv
// package: types, s-box and round functions for the aes-128 ctr unit
`timescale 1ns / 1ps
`default_nettype none
package acu_pkg;
  localparam int ROUNDS = 10;
  localparam int STAGES = ROUNDS + 1;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW = 3'd1,
    REG_IV_HIGH = 3'd2,
    REG_IV_LOW = 3'd3,
    REG_START_BLOCK = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [127:0] ctr;
    logic [127:0] data;
  } work_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits 127-8i
  function automatic logic [7:0] byt(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // next four round-key words from the previous four
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    t[31:24] = t[31:24] ^ rcon(r);
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] t, m;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sbox(byt(s, 4*((c+r)%4)+r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = byt(t, 4*c);
      a1 = byt(t, 4*c+1);
      a2 = byt(t, 4*c+2);
      a3 = byt(t, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      m[127-32*c -: 32] = {a0 ^ al ^ dbl(a0 ^ a1), a1 ^ al ^ dbl(a1 ^ a2),
                           a2 ^ al ^ dbl(a2 ^ a3), a3 ^ al ^ dbl(a3 ^ a0)};
    end
    return (last ? t : m) ^ k;
  endfunction
endpackage
`default_nettype wire

FILE: design/acu_if.sv
// valid/ready stream interfaces for input and result beats
`timescale 1ns / 1ps
`default_nettype none
interface acu_in_if;
  logic valid;
  logic ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic first_block;
  modport source (output valid, data_high, data_low, first_block, input ready);
  modport sink (input valid, data_high, data_low, first_block, output ready);
endinterface

interface acu_out_if;
  logic valid;
  logic ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  modport source (output valid, out_high, out_low, input ready);
  modport sink (input valid, out_high, out_low, output ready);
endinterface
`default_nettype wire

FILE: design/acu_front.sv
// front end: counter bookkeeping and queue of counter/data pairs
`timescale 1ns / 1ps
`default_nettype none
module acu_front import acu_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  acu_in_if.sink            in_ch,
  input  wire logic [63:0]  iv_high,
  input  wire logic [63:0]  iv_low,
  input  wire logic [63:0]  start_block,
  input  wire logic         q_pop,
  output logic              q_valid,
  output work_t             q_head
);
  logic [127:0] ctr_r, ctr_nxt, ctr_use;
  work_t        q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0] cnt_r;
  logic         push;

  assign in_ch.ready = (cnt_r != (QAW+1)'(QDEPTH)) || q_pop;
  assign push = in_ch.valid && in_ch.ready;
  assign ctr_use = in_ch.first_block ? {iv_high, iv_low + start_block} : ctr_r;
  assign ctr_nxt = ctr_use + 128'd1;
  assign q_valid = (cnt_r != '0);
  assign q_head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        ctr_r <= ctr_nxt;
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= '{ctr: ctr_use, data: {in_ch.data_high, in_ch.data_low}};
  end
endmodule
`default_nettype wire

FILE: design/acu_back.sv
// back end: eleven-stage aes pipeline with on-the-fly round keys
`timescale 1ns / 1ps
`default_nettype none
module acu_back import acu_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [127:0]  key,
  input  wire logic          q_valid,
  input  wire work_t         q_head,
  output logic               q_pop,
  acu_out_if.source          out_ch
);
  // stage s holds state after round s and round key s+1
  logic [127:0] st_r [STAGES];
  logic [127:0] rk_r [STAGES];
  logic [127:0] dat_r [STAGES];
  logic [STAGES-1:0] v_r;
  logic [127:0] res_r;
  logic res_v_r;
  logic adv;

  // whole pipe moves only when the output slot frees or is empty
  assign adv = !res_v_r || out_ch.ready;
  assign q_pop = adv && q_valid;
  assign out_ch.valid = res_v_r;
  assign out_ch.out_high = res_r[127:64];
  assign out_ch.out_low = res_r[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      res_v_r <= 1'b0;
    end else if (adv) begin
      v_r <= {v_r[STAGES-2:0], q_valid};
      res_v_r <= v_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= q_head.ctr ^ key;
      rk_r[0] <= key_step(key, 4'd1);
      dat_r[0] <= q_head.data;
      for (int s = 1; s < STAGES; s++) begin
        st_r[s] <= aes_round(st_r[s-1], rk_r[s-1], s == ROUNDS);
        rk_r[s] <= key_step(rk_r[s-1], 4'(s+1));
        dat_r[s] <= dat_r[s-1];
      end
      res_r <= st_r[STAGES-1] ^ dat_r[STAGES-1];
    end
  end
endmodule
`default_nettype wire

FILE: design/aes128_ctr_stream_cipher_unit.sv
// top level of the aes-128 ctr stream cipher unit
`timescale 1ns / 1ps
`default_nettype none
// AES-128 counter mode, one 16-byte beat per clock sustained while the output is
// not held back. An input beat is taken into a four-entry queue together with its
// counter value (reloaded from iv with start_block added to its low half when
// first_block is set); the back end runs it through an eleven-stage round pipeline
// with round keys expanded alongside and then a result register, and the whole
// pipeline stalls while the output is held back. The only feedback is the 128-bit
// counter increment in the front end. Key, iv and start_block are to be written by
// the user through cfg_ only while the unit is idle; the block does not enforce it.
module aes128_ctr_stream_cipher_unit import acu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IW-1:0]  cfg_index,
  input  wire logic [63:0]        cfg_data,
  acu_in_if.sink                  in_ch,
  acu_out_if.source               out_ch
);
  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r, start_block_r;
  logic q_valid, q_pop;
  work_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
      iv_high_r <= '0;
      iv_low_r <= '0;
      start_block_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high_r <= cfg_data;
        REG_KEY_LOW: key_low_r <= cfg_data;
        REG_IV_HIGH: iv_high_r <= cfg_data;
        REG_IV_LOW: iv_low_r <= cfg_data;
        REG_START_BLOCK: start_block_r <= cfg_data;
        default: ;
      endcase
    end
  end

  acu_front u_front (
    .clk, .rst_n, .in_ch,
    .iv_high(iv_high_r), .iv_low(iv_low_r), .start_block(start_block_r),
    .q_pop, .q_valid, .q_head
  );

  acu_back u_back (
    .clk, .rst_n, .key({key_high_r, key_low_r}),
    .q_valid, .q_head, .q_pop, .out_ch
  );
endmodule
`default_nettype wire

FILE: design/acu_checker.sv
// port-level checker for the aes-128 ctr unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_ctr_stream_cipher_unit_macros.svh"
module acu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_high
);
  `ACU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_high))
  `ACU_ASSERT_IMP(a_rdy_when_drain, out_ready, in_ready)
  `ACU_ASSERT_IMP(a_out_known, out_valid, !$isunknown(out_high))
endmodule
bind aes128_ctr_stream_cipher_unit acu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_high(out_ch.out_high)
);
`default_nettype wire
